[hdl/rmo_pkg.sv]
`default_nettype none
package rmo_pkg;

	localparam int MaxRegions = 32;
	localparam int IdxW       = $clog2(MaxRegions);
	localparam int CntW       = $clog2(MaxRegions + 1);
	localparam int AddrW      = $clog2(2 * MaxRegions);

	typedef enum logic [1:0] {
		OP_APPEND  = 2'd0,
		OP_OVERLAY = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef struct packed {
		logic [3:0] rtype;
		logic [7:0] flags;
		logic [4:0] owner;
		logic [2:0] source;
	} attr_t;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] length;
		attr_t       attr;
	} entry_t;

	// controller to datapath
	typedef struct packed {
		logic       load;
		logic       start_append;
		logic       start_overlay;
		logic       rd_user;
		logic       rd_src;
		logic       calc_end;
		logic       split;
		logic       cut;
		logic       put;
		logic [1:0] piece;
		logic       next_idx;
		logic       commit;
		logic       swap;
		logic       fin;
		status_t    status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic count_zero;
		logic read_oob;
		logic put_fail;
		logic last_idx;
	} sts_t;

endpackage
`default_nettype wire

[hdl/rmo_cmd_if.sv]
`default_nettype none
interface rmo_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [63:0] base;
	logic [63:0] length;
	logic [3:0]  region_type;
	logic [7:0]  region_flags;
	logic [4:0]  owner;
	logic [2:0]  region_source;
	logic [4:0]  read_index;

	modport source (output valid, op, base, length, region_type, region_flags, owner,
		region_source, read_index, input ready);
	modport sink (input valid, op, base, length, region_type, region_flags, owner,
		region_source, read_index, output ready);
endinterface
`default_nettype wire

[hdl/rmo_res_if.sv]
`default_nettype none
interface rmo_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [5:0]  entry_count;
	logic [63:0] out_base;
	logic [63:0] out_length;
	logic [3:0]  out_type;
	logic [7:0]  out_flags;
	logic [4:0]  out_owner;
	logic [2:0]  out_source;

	modport source (output valid, status, entry_count, out_base, out_length, out_type,
		out_flags, out_owner, out_source, input ready);
	modport sink (input valid, status, entry_count, out_base, out_length, out_type,
		out_flags, out_owner, out_source, output ready);
endinterface
`default_nettype wire

[hdl/region_map_overlay_engine_unit.sv]
// one word in flight at a time; the region walk over the single memory array sets the overlay cost
// reset clears the region count and bank select; bank contents stay undefined until written
// the result sits in an output register, so a word is taken while the previous result waits
`default_nettype none
module region_map_overlay_engine_unit import rmo_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	rmo_cmd_if.sink   cmd,
	rmo_res_if.source res
);

	cmd_t    dp_cmd;
	sts_t    dp_sts;
	logic    idle;
	logic    accept;
	logic    out_valid_q;
	logic    out_free;
	entry_t  in_entry;
	status_t res_status;
	logic [5:0] res_count;
	entry_t  res_entry;

	// input word accepted only while the controller sits idle
	assign cmd.ready = idle;
	assign accept    = cmd.valid && idle;
	assign out_free  = !out_valid_q || res.ready;

	assign in_entry.base        = cmd.base;
	assign in_entry.length      = cmd.length;
	assign in_entry.attr.rtype  = cmd.region_type;
	assign in_entry.attr.flags  = cmd.region_flags;
	assign in_entry.attr.owner  = cmd.owner;
	assign in_entry.attr.source = cmd.region_source;

	rmo_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.out_free (out_free),
		.sts      (dp_sts),
		.cmd      (dp_cmd),
		.idle     (idle)
	);

	rmo_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (dp_cmd),
		.sts           (dp_sts),
		.in_op         (cmd.op),
		.in_entry      (in_entry),
		.in_read_index (cmd.read_index),
		.res_status    (res_status),
		.res_count     (res_count),
		.res_entry     (res_entry)
	);

	// output word valid flag; the datapath holds the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (dp_cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.status      = res_status;
	assign res.entry_count = res_count;
	assign res.out_base    = res_entry.base;
	assign res.out_length  = res_entry.length;
	assign res.out_type    = res_entry.attr.rtype;
	assign res.out_flags   = res_entry.attr.flags;
	assign res.out_owner   = res_entry.attr.owner;
	assign res.out_source  = res_entry.attr.source;

endmodule
`default_nettype wire

[hdl/rmo_dp.sv]
`default_nettype none
module rmo_dp import rmo_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [1:0]  in_op,
	input  wire entry_t      in_entry,
	input  wire logic [4:0]  in_read_index,
	output status_t          res_status,
	output logic [5:0]       res_count,
	output entry_t           res_entry
);

	// two banks of region entries
	entry_t mem_q [2*MaxRegions];
	entry_t rd_q;

	op_t             op_q;
	entry_t          ov_q;
	logic [63:0]     ov_end_q;
	logic [4:0]      rd_idx_q;

	logic            active_q;
	logic [CntW-1:0] count_q;
	entry_t          atail_q;
	logic [63:0]     atail_end_q;

	logic            bank_q;
	logic [CntW-1:0] wcnt_q;
	entry_t          wtail_q;
	logic [63:0]     wtail_end_q;
	logic [CntW-1:0] src_q;

	logic [63:0]     cur_end_q;
	logic            miss_q;
	logic [63:0]     lo_q;
	logic [63:0]     hi_q;
	entry_t          piece_q [3];
	logic            pen_q [3];

	status_t         res_status_q;
	logic [CntW-1:0] res_count_q;
	entry_t          res_entry_q;

	logic [AddrW-1:0] rd_addr;
	logic [AddrW-1:0] wr_addr;
	logic [IdxW-1:0]  rd_idx;
	logic [IdxW-1:0]  wr_idx;
	logic             rd_bank;
	entry_t           pc;
	logic             pe;
	logic             can_merge;
	logic             full;
	logic [63:0]      pc_end;
	logic [63:0]      merged_len;
	logic             wr_en;
	entry_t           wr_data;

	always_comb begin
		rd_bank = active_q;
		rd_idx  = IdxW'(rd_idx_q);
		if (cmd.rd_src) begin
			rd_idx = src_q[IdxW-1:0];
		end
		rd_addr = AddrW'(rd_idx) + (rd_bank ? AddrW'(MaxRegions) : '0);
	end

	// put unit: append one piece with merge into the working bank
	always_comb begin
		pc         = piece_q[cmd.piece];
		pe         = pen_q[cmd.piece] && (pc.length != '0);
		can_merge  = (wcnt_q != '0) && (wtail_end_q == pc.base) && (wtail_q.attr == pc.attr);
		full       = wcnt_q >= CntW'(MaxRegions);
		pc_end     = pc.base + pc.length;
		merged_len = wtail_q.length + pc.length;
		wr_en      = cmd.put && pe && (can_merge || !full);
		if (can_merge) begin
			wr_idx  = IdxW'(wcnt_q - CntW'(1));
			wr_data = '{base: wtail_q.base, length: merged_len, attr: wtail_q.attr};
		end else begin
			wr_idx  = wcnt_q[IdxW-1:0];
			wr_data = pc;
		end
		wr_addr = AddrW'(wr_idx) + (bank_q ? AddrW'(MaxRegions) : '0);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_user || cmd.rd_src) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= '0;
			op_q     <= OP_NONE;
			wcnt_q   <= '0;
			bank_q   <= 1'b0;
			src_q    <= '0;
		end else begin
			if (cmd.load) begin
				op_q <= op_t'(in_op);
			end
			if (cmd.start_append) begin
				wcnt_q <= count_q;
				bank_q <= active_q;
			end
			if (cmd.start_overlay) begin
				wcnt_q <= '0;
				bank_q <= ~active_q;
				src_q  <= '0;
			end
			if (wr_en && !can_merge) begin
				wcnt_q <= wcnt_q + CntW'(1);
			end
			if (cmd.next_idx) begin
				src_q <= src_q + CntW'(1);
			end
			if (cmd.commit) begin
				count_q <= wcnt_q;
			end
			if (cmd.swap) begin
				active_q <= bank_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ov_q     <= in_entry;
			ov_end_q <= in_entry.base + in_entry.length;
			rd_idx_q <= in_read_index;
		end
		if (cmd.start_append) begin
			wtail_q     <= atail_q;
			wtail_end_q <= atail_end_q;
			piece_q[0]  <= ov_q;
			pen_q[0]    <= 1'b1;
		end
		if (cmd.calc_end) begin
			cur_end_q <= rd_q.base + rd_q.length;
		end
		if (cmd.split) begin
			miss_q <= (cur_end_q <= ov_q.base) || (rd_q.base >= ov_end_q);
			lo_q   <= (ov_q.base > rd_q.base) ? ov_q.base : rd_q.base;
			hi_q   <= (ov_end_q < cur_end_q) ? ov_end_q : cur_end_q;
		end
		if (cmd.cut) begin
			if (miss_q) begin
				piece_q[0] <= rd_q;
				pen_q[0]   <= 1'b1;
				pen_q[1]   <= 1'b0;
				pen_q[2]   <= 1'b0;
			end else begin
				piece_q[0] <= '{base: rd_q.base, length: lo_q - rd_q.base, attr: rd_q.attr};
				pen_q[0]   <= rd_q.base < lo_q;
				piece_q[1] <= '{base: lo_q, length: hi_q - lo_q, attr: ov_q.attr};
				pen_q[1]   <= 1'b1;
				piece_q[2] <= '{base: hi_q, length: cur_end_q - hi_q, attr: rd_q.attr};
				pen_q[2]   <= cur_end_q > hi_q;
			end
		end
		if (wr_en) begin
			wtail_end_q <= pc_end;
			if (can_merge) begin
				wtail_q.length <= merged_len;
			end else begin
				wtail_q <= pc;
			end
		end
		if (cmd.commit) begin
			atail_q     <= wtail_q;
			atail_end_q <= wtail_end_q;
		end
		if (cmd.fin) begin
			res_status_q <= cmd.status;
			res_count_q  <= count_q;
			res_entry_q  <= (op_q == OP_READ && cmd.status == ST_OK) ? rd_q : '0;
		end
	end

	always_comb begin
		sts.op         = op_q;
		sts.count_zero = count_q == '0;
		sts.read_oob   = ({{CntW{1'b0}}, rd_idx_q} >= {5'd0, count_q});
		sts.put_fail   = cmd.put && pe && !can_merge && full;
		sts.last_idx   = ({1'b0, src_q} + (CntW+1)'(1)) >= {1'b0, count_q};
	end

	assign res_status = res_status_q;
	assign res_count  = 6'(res_count_q);
	assign res_entry  = res_entry_q;

endmodule
`default_nettype wire

[hdl/rmo_ctrl.sv]
`default_nettype none
module rmo_ctrl import rmo_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic accept,
	input  wire logic out_free,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      idle
);

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_DECODE = 11'b00000000010,
		S_FETCH  = 11'b00000000100,
		S_LATCH  = 11'b00000001000,
		S_SPLIT  = 11'b00000010000,
		S_CUT    = 11'b00000100000,
		S_PUT0   = 11'b00001000000,
		S_PUT1   = 11'b00010000000,
		S_PUT2   = 11'b00100000000,
		S_COMMIT = 11'b01000000000,
		S_DONE   = 11'b10000000000
	} state_t;

	state_t  state_q, state_d;
	status_t status_q, status_d;
	logic    app_q, app_d;

	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		app_d    = app_q;
		cmd      = '0;
		cmd.status = status_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = accept;
				if (accept) begin
					state_d  = S_DECODE;
					status_d = ST_OK;
				end
			end
			S_DECODE: begin
				unique case (sts.op)
					OP_APPEND: begin
						cmd.start_append = 1'b1;
						app_d            = 1'b1;
						state_d          = S_PUT0;
					end
					OP_OVERLAY: begin
						cmd.start_overlay = 1'b1;
						app_d             = 1'b0;
						state_d           = sts.count_zero ? S_COMMIT : S_FETCH;
					end
					OP_READ: begin
						cmd.rd_user = 1'b1;
						if (sts.read_oob) begin
							status_d = ST_RANGE;
						end
						state_d = S_DONE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_FETCH: begin
				cmd.rd_src = 1'b1;
				state_d    = S_LATCH;
			end
			S_LATCH: begin
				cmd.calc_end = 1'b1;
				state_d      = S_SPLIT;
			end
			S_SPLIT: begin
				cmd.split = 1'b1;
				state_d   = S_CUT;
			end
			S_CUT: begin
				cmd.cut = 1'b1;
				state_d = S_PUT0;
			end
			S_PUT0: begin
				cmd.put   = 1'b1;
				cmd.piece = 2'd0;
				if (sts.put_fail) begin
					status_d = ST_FULL;
					state_d  = S_DONE;
				end else begin
					state_d = app_q ? S_COMMIT : S_PUT1;
				end
			end
			S_PUT1: begin
				cmd.put   = 1'b1;
				cmd.piece = 2'd1;
				if (sts.put_fail) begin
					status_d = ST_FULL;
					state_d  = S_DONE;
				end else begin
					state_d = S_PUT2;
				end
			end
			S_PUT2: begin
				cmd.put      = 1'b1;
				cmd.piece    = 2'd2;
				cmd.next_idx = 1'b1;
				if (sts.put_fail) begin
					status_d = ST_FULL;
					state_d  = S_DONE;
				end else begin
					state_d = sts.last_idx ? S_COMMIT : S_FETCH;
				end
			end
			S_COMMIT: begin
				cmd.commit = 1'b1;
				cmd.swap   = !app_q;
				state_d    = S_DONE;
			end
			S_DONE: begin
				cmd.fin = out_free;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_OK;
			app_q    <= 1'b0;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
			app_q    <= app_d;
		end
	end

	assign idle = state_q == S_IDLE;

endmodule
`default_nettype wire
